// ===== rtl/paged_chunk_run_allocator_unit_macros.svh =====
`ifndef PAGED_CHUNK_RUN_ALLOCATOR_UNIT_MACROS_SVH
`define PAGED_CHUNK_RUN_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PCRA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pcra_pkg.sv =====
`default_nettype none

package pcra_pkg;

	// Bytes per chunk; sizes and offsets are taken apart by this power of two.
	localparam int CHUNK_BYTES = 256;
	// Widest chunk index the fit search reports.
	localparam int MAX_CHUNK_W = 6;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_BAD_SIZE     = 2'd1,
		ST_NO_SPACE     = 2'd2,
		ST_FREE_IGNORED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FREE_CHK,
		S_RESP
	} state_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic                   found;
		logic [MAX_CHUNK_W-1:0] first;
	} fit_t;

endpackage

`default_nettype wire

// ===== rtl/pcra_req_if.sv =====
`default_nettype none

interface pcra_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [15:0] size_bytes;
	logic [1:0]  free_page;
	logic [11:0] free_offset;

	modport source (output valid, req_type, size_bytes, free_page, free_offset, input ready);
	modport sink (input valid, req_type, size_bytes, free_page, free_offset, output ready);
endinterface

`default_nettype wire

// ===== rtl/pcra_res_if.sv =====
`default_nettype none

interface pcra_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [1:0]  grant_page;
	logic [11:0] grant_offset;

	modport source (output valid, status, grant_page, grant_offset, input ready);
	modport sink (input valid, status, grant_page, grant_offset, output ready);
endinterface

`default_nettype wire

// ===== rtl/pcra_ram.sv =====
`default_nettype none

module pcra_ram #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/pcra_fit.sv =====
`default_nettype none

module pcra_fit
	import pcra_pkg::*;
#(
	parameter int CPP = 16
) (
	input  wire logic [CPP-1:0] used_row,
	input  wire logic [CPP-1:0] need_mask,
	output fit_t                fit
);

	logic [CPP-1:0] free_row;
	logic [CPP-1:0] fits;

	assign free_row = ~used_row;

	// a window fits when every chunk under the mask is free; chunks past the
	// page edge shift in as used
	always_comb begin
		for (int c = 0; c < CPP; c++) begin
			fits[c] = &((free_row >> c) | ~need_mask);
		end
	end

	// lowest fitting start wins
	always_comb begin
		fit.found = |fits;
		fit.first = '0;
		for (int c = CPP - 1; c >= 0; c--) begin
			if (fits[c]) begin
				fit.first = MAX_CHUNK_W'(c);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/paged_chunk_run_allocator_unit.sv =====
// Paged chunk-run allocator: first-fit allocation of chunk runs in paged memory.
// Channel req (sink): req_type 0 allocates size_bytes (non-zero multiple of 256),
// req_type 1 frees the run starting at free_page / free_offset.
// Channel res (source): one response per request; status 0 ok, 1 bad size,
// 2 no space, 3 free ignored; grant_page / grant_offset valid on allocate ok,
// zero otherwise. Both channels use valid/ready; a request is taken when both
// are high at a rising edge of clk.
// Flow: a rejected request goes straight to S_RESP, a free passes S_FREE_CHK
// first, an allocate scans pages in S_SCAN. The used bitmap memory holds one
// page per row and the fit search checks one row per cycle, so the page scan
// sets the allocate time. One request is in flight at a time; ready rises
// again once its response sits in the output register.
// Reset: arst_n clears control at once, then a clearing pass over all
// PAGES * CHUNKS_PER_PAGE entries zeroes both memories with ready held low.
// Stall: a response that is not taken holds in the output register; the next
// request may be accepted meanwhile but its response waits until the slot frees.
`default_nettype none

`include "paged_chunk_run_allocator_unit_macros.svh"

module paged_chunk_run_allocator_unit
	import pcra_pkg::*;
#(
	parameter int PAGES           = 4,
	parameter int CHUNKS_PER_PAGE = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	pcra_req_if.sink   req,
	pcra_res_if.source res
);

	localparam int CPP   = CHUNKS_PER_PAGE;
	localparam int TOTAL = PAGES * CPP;
	localparam int PAW   = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int TAW   = $clog2(TOTAL);
	localparam int CW    = $clog2(CPP);
	localparam int LW    = $clog2(CPP + 1);
	localparam int MW    = CPP + 1;

	state_t state_q, state_d;

	// clearing pass counter
	logic [TAW-1:0] clr_q, clr_d;

	// request context
	logic [PAW-1:0] page_q, page_d;
	logic [CW-1:0]  chunk_q, chunk_d;
	logic [TAW-1:0] base_q, base_d;
	logic [LW-1:0]  need_q, need_d;
	logic [CPP-1:0] mask_q, mask_d;

	// pending response, waiting for the output slot
	status_t     pend_status_q, pend_status_d;
	logic [1:0]  pend_page_q, pend_page_d;
	logic [11:0] pend_offset_q, pend_offset_d;

	// output register
	logic        res_valid_q, res_valid_d;
	status_t     res_status_q;
	logic [1:0]  res_page_q;
	logic [11:0] res_offset_q;
	logic        res_load;

	// memory ports
	logic           used_we, len_we;
	logic [PAW-1:0] used_waddr, used_raddr;
	logic [TAW-1:0] len_waddr, len_raddr;
	logic [CPP-1:0] used_wdata, used_rdata;
	logic [LW-1:0]  len_wdata, len_rdata;

	fit_t           fit;
	logic [CW-1:0]  fit_first;
	logic [TAW-1:0] fit_addr;

	// request decode
	logic        accept;
	logic [15:0] need_wide;
	logic [11:0] chunk_wide;
	logic        size_bad;
	logic [CPP-1:0] free_mask;

	pcra_ram #(.DEPTH(PAGES), .WIDTH(CPP)) u_used_ram (
		.clk   (clk),
		.we    (used_we),
		.waddr (used_waddr),
		.wdata (used_wdata),
		.raddr (used_raddr),
		.rdata (used_rdata)
	);

	pcra_ram #(.DEPTH(TOTAL), .WIDTH(LW)) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (len_waddr),
		.wdata (len_wdata),
		.raddr (len_raddr),
		.rdata (len_rdata)
	);

	pcra_fit #(.CPP(CPP)) u_fit (
		.used_row  (used_rdata),
		.need_mask (mask_q),
		.fit       (fit)
	);

	assign fit_first  = CW'(fit.first);
	assign fit_addr   = TAW'(32'(page_q) * CPP + 32'(fit_first));
	assign accept     = req.valid && req.ready;
	assign need_wide  = 16'(req.size_bytes / CHUNK_BYTES);
	assign chunk_wide = 12'(req.free_offset / CHUNK_BYTES);
	assign size_bad   = (req.size_bytes == 16'd0) || ((req.size_bytes % CHUNK_BYTES) != 0);
	// chunks covered by the recorded run of the entry being freed
	assign free_mask  = CPP'((MW'(1) << len_rdata) - MW'(1));

	assign req.ready    = (state_q == S_IDLE);
	assign res.valid    = res_valid_q;
	assign res.status   = res_status_q;
	assign res.grant_page   = res_page_q;
	assign res.grant_offset = res_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		page_q        <= page_d;
		chunk_q       <= chunk_d;
		base_q        <= base_d;
		need_q        <= need_d;
		mask_q        <= mask_d;
		pend_status_q <= pend_status_d;
		pend_page_q   <= pend_page_d;
		pend_offset_q <= pend_offset_d;
		if (res_load) begin
			res_status_q <= pend_status_q;
			res_page_q   <= pend_page_q;
			res_offset_q <= pend_offset_q;
		end
	end

	always_comb begin
		state_d       = state_q;
		clr_d         = clr_q;
		page_d        = page_q;
		chunk_d       = chunk_q;
		base_d        = base_q;
		need_d        = need_q;
		mask_d        = mask_q;
		pend_status_d = pend_status_q;
		pend_page_d   = pend_page_q;
		pend_offset_d = pend_offset_q;
		res_load      = 1'b0;

		used_we    = 1'b0;
		used_waddr = page_q;
		used_wdata = '0;
		used_raddr = page_q;
		len_we     = 1'b0;
		len_waddr  = base_q;
		len_wdata  = '0;
		len_raddr  = base_q;

		unique case (state_q)
			S_CLEAR: begin
				// zero one run-length entry a cycle; bitmap rows are zeroed while clr_q is below PAGES
				len_we    = 1'b1;
				len_waddr = clr_q;
				used_we    = (32'(clr_q) < PAGES);
				used_waddr = PAW'(clr_q);
				clr_d = TAW'(clr_q + 1'b1);
				if (32'(clr_q) == TOTAL - 1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				pend_page_d   = 2'd0;
				pend_offset_d = 12'd0;
				if (req.req_type == REQ_ALLOC) begin
					used_raddr = '0;
				end else begin
					used_raddr = PAW'(req.free_page);
					len_raddr  = TAW'(32'(req.free_page) * CPP + 32'(chunk_wide));
				end
				if (accept) begin
					page_d  = '0;
					need_d  = LW'(need_wide);
					mask_d  = CPP'((MW'(1) << need_wide) - MW'(1));
					chunk_d = CW'(chunk_wide);
					if (req.req_type == REQ_ALLOC) begin
						if (size_bad) begin
							pend_status_d = ST_BAD_SIZE;
							state_d       = S_RESP;
						end else if (32'(need_wide) > CPP) begin
							pend_status_d = ST_NO_SPACE;
							state_d       = S_RESP;
						end else begin
							state_d = S_SCAN;
						end
					end else begin
						page_d = PAW'(req.free_page);
						base_d = TAW'(32'(req.free_page) * CPP + 32'(chunk_wide));
						if (32'(req.free_page) >= PAGES || 32'(chunk_wide) >= CPP) begin
							pend_status_d = ST_FREE_IGNORED;
							state_d       = S_RESP;
						end else begin
							state_d = S_FREE_CHK;
						end
					end
				end
			end
			S_SCAN: begin
				// fetch the next page row while this one is searched
				used_raddr = PAW'(page_q + 1'b1);
				if (fit.found) begin
					used_we       = 1'b1;
					used_wdata    = used_rdata | CPP'(mask_q << fit_first);
					len_we        = 1'b1;
					len_waddr     = fit_addr;
					len_wdata     = need_q;
					pend_status_d = ST_OK;
					pend_page_d   = 2'(page_q);
					pend_offset_d = 12'(12'(fit_first) << 8);
					state_d       = S_RESP;
				end else if (32'(page_q) == PAGES - 1) begin
					pend_status_d = ST_NO_SPACE;
					state_d       = S_RESP;
				end else begin
					page_d = PAW'(page_q + 1'b1);
				end
			end
			S_FREE_CHK: begin
				if (len_rdata == '0) begin
					pend_status_d = ST_FREE_IGNORED;
				end else begin
					len_we        = 1'b1;
					used_we       = 1'b1;
					used_wdata    = used_rdata & ~CPP'(free_mask << chunk_q);
					pend_status_d = ST_OK;
				end
				state_d = S_RESP;
			end
			S_RESP: begin
				// hold until the output slot is free
				if (!res_valid_q || res.ready) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign res_valid_d = res_load || (res_valid_q && !res.ready);

	`PCRA_ASSERT_NOW(a_no_accept_in_clear, clk, arst_n, state_q == S_CLEAR, !req.ready, "request accepted during clearing pass")
	`PCRA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, state_q != S_IDLE && state_q != S_CLEAR, "allocator idle right after taking a request")
	`PCRA_ASSERT_NOW(a_grant_zero_unless_ok, clk, arst_n, res.valid && res.status != ST_OK, res.grant_page == 2'd0 && res.grant_offset == 12'd0, "grant fields set on a failed response")
	`PCRA_ASSERT_NOW(a_grant_aligned, clk, arst_n, res.valid, res.grant_offset[7:0] == 8'd0, "grant offset not chunk aligned")

endmodule

`default_nettype wire
